FILE: src/stfd_pkg.sv
// Shared types and constants for the serial text to display frame block.
// No dependencies; imported by every module in src.
`timescale 1ns / 1ps
`default_nettype none

package stfd_pkg;

    localparam int unsigned NUM_SLOTS = 4;

    typedef logic [7:0] glyph_t;
    typedef logic [1:0] slot_t;
    typedef logic [4:0] points_t;
    typedef logic [7:0] char_t;
    typedef logic [1:0] reg_index_t;

    // ASCII codes the decoder reacts to
    localparam char_t CHAR_ZERO    = 8'd48;
    localparam char_t CHAR_NINE    = 8'd57;
    localparam char_t CHAR_MINUS   = 8'd45;
    localparam char_t CHAR_SPACE   = 8'd32;
    localparam char_t CHAR_LOWLINE = 8'd95;
    localparam char_t CHAR_DOT     = 8'd46;
    localparam char_t CHAR_CR      = 8'd13;
    localparam char_t CHAR_LF      = 8'd10;

    // Configuration register indexes
    localparam reg_index_t REG_DASH_GLYPH       = 2'd0;
    localparam reg_index_t REG_BLANK_GLYPH      = 2'd1;
    localparam reg_index_t REG_UNDERSCORE_GLYPH = 2'd2;

    // Reset values
    localparam glyph_t DASH_GLYPH_RST       = 8'd10;
    localparam glyph_t BLANK_GLYPH_RST      = 8'd11;
    localparam glyph_t UNDERSCORE_GLYPH_RST = 8'd12;

    localparam slot_t   LAST_SLOT = 2'd3;
    localparam points_t POINT_MSB = 5'b10000;

    typedef struct packed {
        glyph_t dash;
        glyph_t blank;
        glyph_t underscore;
    } cfg_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_STORE,
        ACT_POINT,
        ACT_COMMIT
    } action_t;

    typedef struct packed {
        action_t action;
        glyph_t  code;
    } decode_t;

endpackage

`default_nettype wire

FILE: src/stfd_cfg_regs.sv
// Glyph code configuration registers with a plain indexed write port.
// Depends on stfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stfd_cfg_regs
    import stfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire reg_index_t cfg_index,
    input  wire glyph_t     cfg_wdata,
    output cfg_t            cfg
);

    cfg_t cfg_reg;

    // Writes to an unused index are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dash       <= DASH_GLYPH_RST;
            cfg_reg.blank      <= BLANK_GLYPH_RST;
            cfg_reg.underscore <= UNDERSCORE_GLYPH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DASH_GLYPH:       cfg_reg.dash       <= cfg_wdata;
                REG_BLANK_GLYPH:      cfg_reg.blank      <= cfg_wdata;
                REG_UNDERSCORE_GLYPH: cfg_reg.underscore <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: src/stfd_decode.sv
// Character decoder: classifies one ASCII byte and picks its glyph code.
// Depends on stfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stfd_decode
    import stfd_pkg::*;
(
    input  wire char_t ch,
    input  wire cfg_t  cfg,
    output decode_t    dec
);

    always_comb
    begin
        dec.action = ACT_NONE;
        dec.code   = cfg.blank;
        priority if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
        begin
            dec.action = ACT_STORE;
            dec.code   = ch - CHAR_ZERO;
        end
        else if (ch == CHAR_MINUS)
        begin
            dec.action = ACT_STORE;
            dec.code   = cfg.dash;
        end
        else if (ch == CHAR_SPACE)
        begin
            dec.action = ACT_STORE;
            dec.code   = cfg.blank;
        end
        else if (ch == CHAR_LOWLINE)
        begin
            dec.action = ACT_STORE;
            dec.code   = cfg.underscore;
        end
        else if (ch == CHAR_DOT)
        begin
            dec.action = ACT_POINT;
        end
        else if (ch == CHAR_CR || ch == CHAR_LF)
        begin
            dec.action = ACT_COMMIT;
        end
        else
        begin
            dec.action = ACT_NONE;
        end
    end

endmodule

`default_nettype wire

FILE: src/stfd_frame.sv
// Pending and shown frame state; the shown registers double as result payload.
// Depends on stfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stfd_frame
    import stfd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire decode_t dec,
    input  wire glyph_t  blank_glyph,
    output glyph_t       shown [NUM_SLOTS],
    output points_t      shown_mask,
    output logic         committed
);

    slot_t   slot_reg,        slot_next;
    glyph_t  pend_reg  [NUM_SLOTS];
    glyph_t  pend_next [NUM_SLOTS];
    points_t pend_pts_reg,    pend_pts_next;
    glyph_t  shown_reg [NUM_SLOTS];
    glyph_t  shown_next [NUM_SLOTS];
    points_t shown_pts_reg,   shown_pts_next;
    logic    committed_reg,   committed_next;

    // Next-state for one beat
    always_comb
    begin
        logic   commit;
        glyph_t stored [NUM_SLOTS];

        commit        = 1'b0;
        slot_next     = slot_reg;
        pend_pts_next = pend_pts_reg;
        stored        = pend_reg;

        unique case (dec.action)
            ACT_STORE:
            begin
                stored[slot_reg] = dec.code;
                if (slot_reg == LAST_SLOT)
                    commit = 1'b1;
                else
                    slot_next = slot_reg + 2'd1;
            end
            ACT_POINT:  pend_pts_next = pend_pts_reg | (POINT_MSB >> slot_reg);
            ACT_COMMIT: commit = 1'b1;
            default:    ;
        endcase

        pend_next      = stored;
        shown_next     = shown_reg;
        shown_pts_next = shown_pts_reg;
        committed_next = commit;

        // Commit copies pending to shown and refills pending with blank
        if (commit)
        begin
            slot_next      = '0;
            shown_next     = stored;
            shown_pts_next = pend_pts_reg;
            pend_pts_next  = '0;
            for (int k = 0; k < NUM_SLOTS; k++)
                pend_next[k] = blank_glyph;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            pend_pts_reg  <= '0;
            shown_pts_reg <= '0;
            committed_reg <= 1'b0;
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                pend_reg[k]  <= '0;
                shown_reg[k] <= UNDERSCORE_GLYPH_RST;
            end
        end
        else if (step)
        begin
            slot_reg      <= slot_next;
            pend_reg      <= pend_next;
            pend_pts_reg  <= pend_pts_next;
            shown_reg     <= shown_next;
            shown_pts_reg <= shown_pts_next;
            committed_reg <= committed_next;
        end
    end

    assign shown      = shown_reg;
    assign shown_mask = shown_pts_reg;
    assign committed  = committed_reg;

endmodule

`default_nettype wire

FILE: src/serial_text_to_four_digit_display.sv
// Top level: input beat register, decoder, frame state and result handshake.
// Depends on stfd_pkg, stfd_cfg_regs, stfd_decode and stfd_frame.
//
//   Channel  Signals                                  Beat
//   in       in_valid / in_stall / rx_byte            one received character
//   out      out_valid / out_stall / shown_*,         shown frame after that
//            frame_committed                          character
//   cfg      cfg_we / cfg_index / cfg_wdata           one glyph register write
//
// Each accepted character is held in the input register, then goes through
// decode and frame update into the result registers. One character is accepted
// every cycle while out_stall is low.
// A stalled result holds the frame and input stage; in_stall rises once the
// input register is full behind it. Reset clears the frame to underscore glyphs.
`timescale 1ns / 1ps
`default_nettype none

module serial_text_to_four_digit_display
    import stfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire char_t      rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output glyph_t          shown_digit0,
    output glyph_t          shown_digit1,
    output glyph_t          shown_digit2,
    output glyph_t          shown_digit3,
    output points_t         shown_points,
    output logic            frame_committed,
    input  wire logic       cfg_we,
    input  wire reg_index_t cfg_index,
    input  wire glyph_t     cfg_wdata
);

    logic    in_valid_reg;
    char_t   in_byte_reg;
    logic    out_valid_reg;
    logic    out_ready;
    logic    step;
    cfg_t    cfg;
    decode_t dec;
    glyph_t  shown [NUM_SLOTS];

    // Result stage frees up when empty or its beat is taken
    assign out_ready = !out_valid_reg || !out_stall;
    assign step      = in_valid_reg && out_ready;
    assign in_stall  = in_valid_reg && !out_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= rx_byte;
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    stfd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    stfd_decode u_decode (
        .ch  (in_byte_reg),
        .cfg (cfg),
        .dec (dec)
    );

    stfd_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .dec         (dec),
        .blank_glyph (cfg.blank),
        .shown       (shown),
        .shown_mask  (shown_points),
        .committed   (frame_committed)
    );

    assign out_valid    = out_valid_reg;
    assign shown_digit0 = shown[0];
    assign shown_digit1 = shown[1];
    assign shown_digit2 = shown[2];
    assign shown_digit3 = shown[3];

endmodule

`default_nettype wire
